// File: rtl/assert_macros.svh
// assertion macros used by rtl/plane_triangle_intersect.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PTI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define PTI_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define PTI_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PTI_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/pti_pkg.sv
// types and constants of the plane/triangle crossing pipeline
package pti_pkg;
  localparam int COORD_W   = 32;
  localparam int NORM_W    = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = DIFF_W + NORM_W;
  localparam int DIST_W    = PROD_W + 2;
  localparam int MAG_W     = DIST_W + 1;
  localparam int REM_W     = MAG_W + 1;
  localparam int S_FRAC    = 24;
  localparam int Q_W       = S_FRAC + 1;
  localparam int HI_W      = DIFF_W - S_FRAC;
  localparam int PHI_W     = Q_W + HI_W;
  localparam int PLO_W     = Q_W + S_FRAC;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = COORD_W;
  localparam logic [PLO_W:0] ROUND_HALF = (PLO_W + 1)'(1) << (S_FRAC - 1);
  localparam logic [Q_W-1:0] S_ONE = Q_W'(1) << S_FRAC;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [2:0][COORD_W-1:0] vec_t;

  typedef struct packed {
    coord_t corner0_x;
    coord_t corner0_y;
    coord_t corner0_z;
    coord_t corner1_x;
    coord_t corner1_y;
    coord_t corner1_z;
    coord_t corner2_x;
    coord_t corner2_y;
    coord_t corner2_z;
  } tri_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
  } seg_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    coord_t px;
    coord_t py;
    coord_t pz;
  } plane_t;

  typedef struct packed {
    vec_t va;
    vec_t vb;
  } edge_t;

  typedef struct packed {
    edge_t ends;
    logic [MAG_W-1:0] num;
    logic [MAG_W-1:0] den;
  } crossing_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_X = 3'd0,
    REG_NORMAL_Y = 3'd1,
    REG_NORMAL_Z = 3'd2,
    REG_POINT_X  = 3'd3,
    REG_POINT_Y  = 3'd4,
    REG_POINT_Z  = 3'd5
  } cfg_reg_t;

  function automatic logic [MAG_W-1:0] dist_mag(logic signed [DIST_W-1:0] d);
    logic signed [MAG_W-1:0] e;
    e = MAG_W'(d);
    return e[MAG_W-1] ? MAG_W'(-e) : MAG_W'(e);
  endfunction
endpackage

// File: rtl/pti_tri_if.sv
// triangle input channel
interface pti_tri_if;
  logic          valid;
  logic          ready;
  pti_pkg::tri_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: rtl/pti_seg_if.sv
// segment result channel
interface pti_seg_if;
  logic          valid;
  logic          ready;
  pti_pkg::seg_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: rtl/pti_dist.sv
// corner distances to the plane and crossing edge selection, four stages
module pti_dist (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                valid_i,
  input  pti_pkg::tri_t       tri_i,
  input  pti_pkg::plane_t     plane_i,
  output logic                valid_o,
  output pti_pkg::crossing_t  x0_o,
  output pti_pkg::crossing_t  x1_o
);
  pti_pkg::vec_t corner [3];
  pti_pkg::vec_t pnt;
  logic signed [pti_pkg::NORM_W-1:0] nrm [3];

  logic signed [pti_pkg::DIFF_W-1:0] diff_nxt [3][3];
  logic signed [pti_pkg::DIFF_W-1:0] diff_r   [3][3];
  logic signed [pti_pkg::PROD_W-1:0] prod_nxt [3][3];
  logic signed [pti_pkg::PROD_W-1:0] prod_r   [3][3];
  logic signed [pti_pkg::DIST_W-1:0] dist_nxt [3];
  logic signed [pti_pkg::DIST_W-1:0] dist_r   [3];
  pti_pkg::vec_t v1_r [3];
  pti_pkg::vec_t v2_r [3];
  pti_pkg::vec_t v3_r [3];
  logic [2:0] vld_r;
  logic       vld4_r;

  logic [2:0] neg;
  logic       c01, c12, c20, hit;
  pti_pkg::crossing_t x0_nxt, x1_nxt, x0_r, x1_r;
  logic [pti_pkg::MAG_W-1:0] mag [3];

  assign corner[0] = {tri_i.corner0_z, tri_i.corner0_y, tri_i.corner0_x};
  assign corner[1] = {tri_i.corner1_z, tri_i.corner1_y, tri_i.corner1_x};
  assign corner[2] = {tri_i.corner2_z, tri_i.corner2_y, tri_i.corner2_x};
  assign pnt       = {plane_i.pz, plane_i.py, plane_i.px};
  assign nrm[0]    = plane_i.nx;
  assign nrm[1]    = plane_i.ny;
  assign nrm[2]    = plane_i.nz;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        diff_nxt[c][k] = pti_pkg::DIFF_W'($signed(corner[c][k]))
                       - pti_pkg::DIFF_W'($signed(pnt[k]));
        prod_nxt[c][k] = pti_pkg::PROD_W'(diff_r[c][k]) * pti_pkg::PROD_W'(nrm[k]);
      end
      dist_nxt[c] = pti_pkg::DIST_W'(prod_r[c][0]) + pti_pkg::DIST_W'(prod_r[c][1])
                  + pti_pkg::DIST_W'(prod_r[c][2]);
      neg[c] = dist_r[c][pti_pkg::DIST_W-1];
      mag[c] = pti_pkg::dist_mag(dist_r[c]);
    end
  end

  // zero counts as positive, so only the sign bit decides
  always_comb begin
    c01 = neg[0] ^ neg[1];
    c12 = neg[1] ^ neg[2];
    c20 = neg[2] ^ neg[0];
    hit = c01 | c12 | c20;
    if (c01) begin
      x0_nxt.ends.va = v3_r[0];
      x0_nxt.ends.vb = v3_r[1];
      x0_nxt.num     = mag[0];
      x0_nxt.den     = mag[0] + mag[1];
    end else begin
      x0_nxt.ends.va = v3_r[1];
      x0_nxt.ends.vb = v3_r[2];
      x0_nxt.num     = mag[1];
      x0_nxt.den     = mag[1] + mag[2];
    end
    if (c01 && c12) begin
      x1_nxt.ends.va = v3_r[1];
      x1_nxt.ends.vb = v3_r[2];
      x1_nxt.num     = mag[1];
      x1_nxt.den     = mag[1] + mag[2];
    end else begin
      x1_nxt.ends.va = v3_r[2];
      x1_nxt.ends.vb = v3_r[0];
      x1_nxt.num     = mag[2];
      x1_nxt.den     = mag[2] + mag[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld_r  <= {vld_r[1:0], valid_i};
      vld4_r <= vld_r[2] & hit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= diff_nxt;
      prod_r <= prod_nxt;
      dist_r <= dist_nxt;
      v1_r   <= corner;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      x0_r   <= x0_nxt;
      x1_r   <= x1_nxt;
    end
  end

  assign valid_o = vld4_r;
  assign x0_o    = x0_r;
  assign x1_o    = x1_r;
endmodule

// File: rtl/pti_div.sv
// restoring divider for the crossing ratio, one quotient bit per stage
module pti_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       valid_i,
  input  pti_pkg::crossing_t         x_i,
  output logic                       valid_o,
  output logic [pti_pkg::Q_W-1:0]    q_o,
  output pti_pkg::edge_t             ends_o
);
  localparam int N = pti_pkg::Q_W;

  logic [N-1:0]                  vld_r;
  logic [pti_pkg::REM_W-1:0]     rem_r   [N];
  logic [pti_pkg::REM_W-1:0]     rem_nxt [N];
  logic [pti_pkg::REM_W-1:0]     trial   [N];
  logic [pti_pkg::MAG_W-1:0]     den_r   [N];
  logic [pti_pkg::MAG_W-1:0]     dsel    [N];
  logic [N-1:0]                  q_r     [N];
  logic [N-1:0]                  q_nxt   [N];
  logic [N-1:0]                  qsel    [N];
  pti_pkg::edge_t                ends_r  [N];
  pti_pkg::edge_t                esel    [N];
  logic [N-1:0]                  ge;

  for (genvar k = 0; k < N; k++) begin : g_stage
    if (k == 0) begin : g_first
      // integer bit: set only when the far end lies on the plane
      assign trial[k] = pti_pkg::REM_W'(x_i.num);
      assign qsel[k]  = '0;
      assign dsel[k]  = x_i.den;
      assign esel[k]  = x_i.ends;
    end else begin : g_next
      assign trial[k] = {rem_r[k-1][pti_pkg::REM_W-2:0], 1'b0};
      assign qsel[k]  = {q_r[k-1][N-2:0], 1'b0};
      assign dsel[k]  = den_r[k-1];
      assign esel[k]  = ends_r[k-1];
    end
    assign ge[k]      = trial[k] >= pti_pkg::REM_W'(dsel[k]);
    assign rem_nxt[k] = ge[k] ? trial[k] - pti_pkg::REM_W'(dsel[k]) : trial[k];
    assign q_nxt[k]   = qsel[k] | N'(ge[k]);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt[k];
        q_r[k]    <= q_nxt[k];
        den_r[k]  <= dsel[k];
        ends_r[k] <= esel[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], valid_i};
    end
  end

  assign valid_o = vld_r[N-1];
  assign q_o     = q_r[N-1];
  assign ends_o  = ends_r[N-1];
endmodule

// File: rtl/pti_lerp.sv
// crossing point va + round(s*(vb-va)) for three axes, three stages
module pti_lerp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     valid_i,
  input  logic [pti_pkg::Q_W-1:0]  s_i,
  input  pti_pkg::edge_t           ends_i,
  output logic                     valid_o,
  output pti_pkg::vec_t            pt_o
);
  logic [2:0] vld_r;

  logic signed [pti_pkg::DIFF_W-1:0] diff [3];
  logic [pti_pkg::DIFF_W-1:0]        mag  [3];
  logic [pti_pkg::Q_W-1:0]           s_r;
  pti_pkg::vec_t                     a1_r, a2_r, pt_r, pt_nxt;
  logic [2:0]                        neg1_r, neg2_r;
  logic [pti_pkg::HI_W-1:0]          hi_r [3];
  logic [pti_pkg::S_FRAC-1:0]        lo_r [3];
  logic [pti_pkg::PHI_W-1:0]         phi_r [3];
  logic [pti_pkg::PLO_W-1:0]         plo_r [3];
  logic [pti_pkg::PLO_W:0]           rnd  [3];
  pti_pkg::coord_t                   prod [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = pti_pkg::DIFF_W'($signed(ends_i.vb[k]))
              - pti_pkg::DIFF_W'($signed(ends_i.va[k]));
      mag[k]  = diff[k][pti_pkg::DIFF_W-1] ? pti_pkg::DIFF_W'(-diff[k])
                                           : pti_pkg::DIFF_W'(diff[k]);
      // the split product sums back to the rounded full product
      rnd[k]  = (pti_pkg::PLO_W + 1)'(plo_r[k]) + pti_pkg::ROUND_HALF;
      prod[k] = pti_pkg::COORD_W'(phi_r[k])
              + pti_pkg::COORD_W'(rnd[k] >> pti_pkg::S_FRAC);
      pt_nxt[k] = neg2_r[k] ? a2_r[k] - prod[k] : a2_r[k] + prod[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r    <= s_i;
      a1_r   <= ends_i.va;
      a2_r   <= a1_r;
      neg2_r <= neg1_r;
      pt_r   <= pt_nxt;
      for (int k = 0; k < 3; k++) begin
        neg1_r[k] <= diff[k][pti_pkg::DIFF_W-1];
        hi_r[k]   <= mag[k][pti_pkg::DIFF_W-1:pti_pkg::S_FRAC];
        lo_r[k]   <= mag[k][pti_pkg::S_FRAC-1:0];
        phi_r[k]  <= pti_pkg::PHI_W'(s_r) * pti_pkg::PHI_W'(hi_r[k]);
        plo_r[k]  <= pti_pkg::PLO_W'(s_r) * pti_pkg::PLO_W'(lo_r[k]);
      end
    end
  end

  assign valid_o = vld_r[2];
  assign pt_o    = pt_r;
endmodule

// File: rtl/plane_triangle_intersect.sv
// Cuts one triangle per item with a configured plane and returns the crossing
// segment. Items enter back to back, one per cycle while no result waits at the
// output. Each passes three stages of distance arithmetic, one stage of edge
// selection, a 25-stage ratio divider (one quotient bit per stage) and three
// stages of interpolation whose last register drives the output. A triangle
// that the plane does not cross gives no result. The whole pipeline holds
// while a result waits at the output, so a stalled consumer stalls input.
// Configuration is written with cfg_we, cfg_index and cfg_data; the user must
// write it only while no item is in flight, which the block does not enforce.
`include "assert_macros.svh"
module plane_triangle_intersect (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pti_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pti_pkg::CFG_W-1:0]         cfg_data,
  pti_tri_if.sink                           in_tri,
  pti_seg_if.source                         out_seg
);
  pti_pkg::plane_t    plane_r;
  logic               en;
  logic               sel_v, div0_v, div1_v, lrp0_v, lrp1_v;
  pti_pkg::crossing_t x0, x1;
  logic [pti_pkg::Q_W-1:0] q0, q1;
  pti_pkg::edge_t     e0, e1;
  pti_pkg::vec_t      p0, p1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r.nx <= '0;
      plane_r.ny <= '0;
      plane_r.nz <= pti_pkg::NORM_W'(1);
      plane_r.px <= '0;
      plane_r.py <= '0;
      plane_r.pz <= '0;
    end else if (cfg_we) begin
      unique case (pti_pkg::cfg_reg_t'(cfg_index))
        pti_pkg::REG_NORMAL_X: plane_r.nx <= cfg_data[pti_pkg::NORM_W-1:0];
        pti_pkg::REG_NORMAL_Y: plane_r.ny <= cfg_data[pti_pkg::NORM_W-1:0];
        pti_pkg::REG_NORMAL_Z: plane_r.nz <= cfg_data[pti_pkg::NORM_W-1:0];
        pti_pkg::REG_POINT_X:  plane_r.px <= cfg_data;
        pti_pkg::REG_POINT_Y:  plane_r.py <= cfg_data;
        pti_pkg::REG_POINT_Z:  plane_r.pz <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en           = !lrp0_v || out_seg.ready;
  assign in_tri.ready = en;

  pti_dist u_dist (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_i(in_tri.valid), .tri_i(in_tri.data),
    .plane_i(plane_r), .valid_o(sel_v), .x0_o(x0), .x1_o(x1)
  );

  pti_div u_div0 (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_i(sel_v), .x_i(x0),
    .valid_o(div0_v), .q_o(q0), .ends_o(e0)
  );

  pti_div u_div1 (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_i(sel_v), .x_i(x1),
    .valid_o(div1_v), .q_o(q1), .ends_o(e1)
  );

  pti_lerp u_lerp0 (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_i(div0_v), .s_i(q0), .ends_i(e0),
    .valid_o(lrp0_v), .pt_o(p0)
  );

  pti_lerp u_lerp1 (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_i(div1_v), .s_i(q1), .ends_i(e1),
    .valid_o(lrp1_v), .pt_o(p1)
  );

  assign out_seg.valid        = lrp0_v;
  assign out_seg.data.start_x = p0[0];
  assign out_seg.data.start_y = p0[1];
  assign out_seg.data.start_z = p0[2];
  assign out_seg.data.end_x   = p1[0];
  assign out_seg.data.end_y   = p1[1];
  assign out_seg.data.end_z   = p1[2];

  `PTI_ASSERT_NEVER(a_den_zero, clk, rst_n, sel_v && (x0.den == '0 || x1.den == '0))
  `PTI_ASSERT_IMPLY(a_ratio_range, clk, rst_n, div0_v, q0 <= pti_pkg::S_ONE && q1 <= pti_pkg::S_ONE)
  `PTI_ASSERT_IMPLY(a_lanes_lockstep, clk, rst_n, div0_v || lrp0_v, div1_v == div0_v && lrp1_v == lrp0_v)
  `PTI_ASSERT_IMPLY(a_stall_cause, clk, rst_n, !in_tri.ready, out_seg.valid && !out_seg.ready)
endmodule

// File: sim/tb_plane_triangle_intersect.sv
// testbench for the plane/triangle crossing block: directed and random triangles checked against a predictor
module tb_plane_triangle_intersect;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SFRAC = 24;
  localparam int LATENCY = 32;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_TRIS = 1330;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [pti_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pti_pkg::CFG_W-1:0] cfg_data;

  pti_tri_if in_tri();
  pti_seg_if out_seg();

  plane_triangle_intersect u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_tri(in_tri.sink), .out_seg(out_seg.source)
  );

  // predictor of crossing segments and the queue of segments still owed
  class seg_scoreboard;
    logic signed [15:0] nrm[3];
    logic signed [31:0] pnt[3];
    pti_pkg::seg_t owed[$];
    int mismatches;
    int segs_seen;

    function new();
      nrm[0] = 0; nrm[1] = 0; nrm[2] = 1;
      pnt[0] = 0; pnt[1] = 0; pnt[2] = 0;
      mismatches = 0;
      segs_seen = 0;
    endfunction

    function void set_reg(pti_pkg::cfg_reg_t idx, logic [31:0] val);
      case (idx)
        pti_pkg::REG_NORMAL_X: nrm[0] = val[15:0];
        pti_pkg::REG_NORMAL_Y: nrm[1] = val[15:0];
        pti_pkg::REG_NORMAL_Z: nrm[2] = val[15:0];
        pti_pkg::REG_POINT_X: pnt[0] = val;
        pti_pkg::REG_POINT_Y: pnt[1] = val;
        pti_pkg::REG_POINT_Z: pnt[2] = val;
        default: ;
      endcase
    endfunction

    function logic signed [63:0] plane_dist(logic signed [31:0] v[3]);
      logic signed [63:0] acc;
      acc = 0;
      for (int k = 0; k < 3; k++)
        acc += (64'(v[k]) - 64'(pnt[k])) * 64'(nrm[k]);
      return acc;
    endfunction

    // s = |da|/(|da|+|db|), truncated to 24 fraction bits
    function logic [63:0] frac_s(logic signed [63:0] da, logic signed [63:0] db);
      logic [63:0] ma, mb;
      logic [127:0] num, den;
      ma = da < 0 ? -da : da;
      mb = db < 0 ? -db : db;
      num = 128'(ma);
      den = num + 128'(mb);
      if (den == 0) return 0;
      return 64'((num << SFRAC) / den);
    endfunction

    function logic [31:0] blend(logic signed [31:0] a, logic signed [31:0] b,
                                logic [63:0] s);
      logic signed [63:0] diff;
      logic [63:0] m, prod;
      diff = 64'(b) - 64'(a);
      m = diff < 0 ? -diff : diff;
      prod = s * (m >> SFRAC) + ((s * (m & 64'hFFFFFF) + 64'h800000) >> SFRAC);
      return diff < 0 ? 32'(64'(a) - prod) : 32'(64'(a) + prod);
    endfunction

    function void note_tri(pti_pkg::tri_t t);
      logic signed [31:0] v[3][3];
      logic signed [63:0] d[3];
      logic [31:0] pt[2][3];
      logic [63:0] s;
      int found;
      int b;
      pti_pkg::seg_t r;
      v[0] = '{t.corner0_x, t.corner0_y, t.corner0_z};
      v[1] = '{t.corner1_x, t.corner1_y, t.corner1_z};
      v[2] = '{t.corner2_x, t.corner2_y, t.corner2_z};
      for (int c = 0; c < 3; c++) d[c] = plane_dist(v[c]);
      found = 0;
      for (int e = 0; e < 3; e++) begin
        b = (e + 1) % 3;
        if ((d[e] < 0) != (d[b] < 0)) begin
          if (found < 2) begin
            s = frac_s(d[e], d[b]);
            for (int k = 0; k < 3; k++) pt[found][k] = blend(v[e][k], v[b][k], s);
          end
          found++;
        end
      end
      if (found == 2) begin
        r = '{pt[0][0], pt[0][1], pt[0][2], pt[1][0], pt[1][1], pt[1][2]};
        owed.push_back(r);
      end
    endfunction

    function void check_seg(pti_pkg::seg_t got);
      pti_pkg::seg_t want;
      segs_seen++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected segment %h", got);
        return;
      end
      want = owed.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("segment mismatch: expected %h got %h", want, got);
      end
    endfunction
  endclass

  seg_scoreboard sb;
  int idle_cycles;
  int tris_sent;
  bit watchdog_tripped;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial sb = new();

  // result side: random ready, check every accepted segment
  initial begin
    int wait_n;
    forever begin
      wait_n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
      if (wait_n > 0) begin
        out_seg.ready <= 0;
        repeat (wait_n) @(posedge clk);
      end
      out_seg.ready <= 1;
      do @(posedge clk); while (!(out_seg.valid && rst_n));
      sb.check_seg(out_seg.data);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tri.valid && in_tri.ready) || (out_seg.valid && out_seg.ready))
      idle_cycles <= 0;
    else if (rst_n && !watchdog_tripped) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        watchdog_tripped = 1;
        $display("plane_triangle_intersect verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(pti_pkg::cfg_reg_t idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_plane(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                           logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    write_reg(pti_pkg::REG_NORMAL_X, {{16{nx[15]}}, nx});
    write_reg(pti_pkg::REG_NORMAL_Y, {{16{ny[15]}}, ny});
    write_reg(pti_pkg::REG_NORMAL_Z, {{16{nz[15]}}, nz});
    write_reg(pti_pkg::REG_POINT_X, px);
    write_reg(pti_pkg::REG_POINT_Y, py);
    write_reg(pti_pkg::REG_POINT_Z, pz);
    cfg_we <= 0;
  endtask

  task automatic send_tri(pti_pkg::tri_t t);
    int wait_n;
    wait_n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    if (wait_n > 0) begin
      in_tri.valid <= 0;
      repeat (wait_n) @(posedge clk);
    end
    in_tri.valid <= 1;
    in_tri.data <= t;
    do @(posedge clk); while (!in_tri.ready);
    sb.note_tri(t);
    tris_sent++;
  endtask

  task automatic drain();
    in_tri.valid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  function automatic pti_pkg::tri_t rnd_tri(int mode);
    pti_pkg::tri_t t;
    logic [31:0] f[9];
    for (int i = 0; i < 9; i++)
      f[i] = $urandom_range(0, 7) == 0 ? rnd_coord($urandom_range(0, 3)) : rnd_coord(mode);
    t = '{f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8]};
    return t;
  endfunction

  initial begin
    pti_pkg::tri_t t;
    int mode;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    in_tri.valid = 0;
    in_tri.data = '0;
    idle_cycles = 0;
    tris_sent = 0;
    watchdog_tripped = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset plane z = 0: straddling, touching, all-above and full-range triangles
    send_tri('{0, 0, -32'sh10000, 32'sh10000, 0, 32'sh10000, 0, 32'sh10000, 32'sh10000});
    send_tri('{0, 0, 0, 32'sh10000, 0, -32'sh10000, 0, 32'sh10000, 32'sh10000});
    send_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0});
    send_tri('{0, 0, 5, 1, 1, 6, 2, 2, 7});
    send_tri('{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
               32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 0, 32'h80000000});
    send_tri('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
               32'h80000000, 32'h80000000, 0, 0, 32'hFFFFFFFF});
    send_tri('{1, 2, -1, 3, 4, 1, 5, 6, -1});
    send_tri('{0, 0, -1, 0, 0, -1, 0, 0, 0});
    drain();
    // zero normal: nothing crosses
    set_plane(16'h0, 16'h0, 16'h0, 32'h1234, 32'h0, 32'h0);
    send_tri('{0, 0, -32'sh10000, 1, 1, 32'sh10000, 2, 2, 3});
    drain();
    // extreme normals and points
    set_plane(16'h8000, 16'h7FFF, 16'h8000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    for (int i = 0; i < 8; i++) send_tri(rnd_tri(i % 4));
    drain();
    set_plane(16'h7FFF, 16'h8000, 16'h7FFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    for (int i = 0; i < 8; i++) send_tri(rnd_tri(i % 4));
    drain();

    // random phases, each with a fresh plane; most pass through a small region, every third is fully random
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 0)
        set_plane(16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom, $urandom, $urandom);
      else
        set_plane(16'($urandom_range(0, 200) - 100), 16'($urandom_range(0, 200) - 100),
                  16'($urandom_range(0, 200) - 100),
                  rnd_coord(1), rnd_coord(1), rnd_coord(1));
      mode = ph % 3 == 0 ? 0 : (ph % 2 ? 1 : 3);
      for (int i = 0; i < RANDOM_TRIS / 10; i++) begin
        // one triangle in five takes a random coordinate mode; send_tri adds random gaps, some of them zero
        t = rnd_tri($urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : mode);
        send_tri(t);
      end
      drain();
    end

    $display("sent %0d triangles over several planes, %0d segments checked",
             tris_sent, sb.segs_seen);
    if (sb.mismatches == 0 && sb.owed.size() == 0)
      $display("plane_triangle_intersect verification clean");
    else
      $display("plane_triangle_intersect verification failed");
    $finish;
  end
endmodule
